// File: hdl/qslerp_pkg.sv
`default_nettype none

package qslerp_pkg;

    // Default number of fraction bits on the quaternion and amount ports.
    localparam int FRAC_BITS_DEF = 14;

    // Shared datapath sizes.
    localparam int CORDIC_STEPS = 30;
    localparam int ANG_W        = 34;
    localparam int SQRT_STEPS   = 31;
    localparam int DIV_STEPS    = 61;
    localparam int QUO_W        = 62;
    localparam int MAG_W        = 31;

    // Angles and gains in Q30.
    localparam logic signed [ANG_W-1:0] PI30      = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI30 = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] GAIN30    = 34'sd652032874;
    localparam logic [MAG_W-1:0]        ONE30     = 31'd1073741824;

    // Operands that travel beside the arithmetic units.
    typedef struct packed {
        logic [3:0][15:0]  p;
        logic [3:0][16:0]  q;
        logic [15:0]       t;
        logic              sp;
        logic              cneg;
        logic              szero;
        logic [MAG_W-1:0]  m;
        logic [MAG_W-1:0]  s;
    } t_side;

    // Rounded arctangent of 2^-idx in Q30.
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hdl/quaternion_slerp_unit.sv
`default_nettype none

// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_p_*, i_q_*, i_amount, i_shortest_path
// result    out        o_valid / i_stall   o_r_*, o_degenerate
//
// One transfer per cycle in each direction unless a held result stalls the pipeline; an item
// passes 167 register stages on its way from input transfer to result.
// The latency is set by the 31-step square root, the vectoring and rotation CORDIC chains
// of 30 steps each, and the 61-step quotient units.
// Reset is synchronous and active low; it clears only the valid bits of the stages.
// A stalled result freezes the whole pipeline, so o_stall rises only while a result waits.
module quaternion_slerp_unit import qslerp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_p_w,
    input  logic signed [15:0] i_p_x,
    input  logic signed [15:0] i_p_y,
    input  logic signed [15:0] i_p_z,
    input  logic signed [15:0] i_q_w,
    input  logic signed [15:0] i_q_x,
    input  logic signed [15:0] i_q_y,
    input  logic signed [15:0] i_q_z,
    input  logic signed [15:0] i_amount,
    input  logic               i_shortest_path,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_r_w,
    output logic signed [15:0] o_r_x,
    output logic signed [15:0] o_r_y,
    output logic signed [15:0] o_r_z,
    output logic               o_degenerate
);

    // Register level at which each value is ready.
    localparam int L_M   = 2;
    localparam int L_RAD = 4;
    localparam int L_S   = L_RAD + SQRT_STEPS;
    localparam int L_VEC = L_S + CORDIC_STEPS;
    localparam int L_ANG = L_VEC + 1;
    localparam int L_TP  = L_ANG + 1;
    localparam int L_TA  = L_TP + 1;
    localparam int L_SIN = L_TA + CORDIC_STEPS + 2;
    localparam int L_DIV = L_SIN + DIV_STEPS + 2;
    localparam int L_X1  = L_DIV + 1;
    localparam int L_X2  = L_X1 + 1;
    localparam int L_X3  = L_X2 + 1;
    localparam int L_OUT = L_X3 + 1;

    // Scaling of the dot product to Q30 and of the amount product.
    localparam int SH   = 2 * FRAC_BITS - 30;
    localparam int SH_R = (SH > 0) ? SH : 0;
    localparam int SH_L = (SH < 0) ? -SH : 0;
    localparam logic [63:0]        DOT_LIM = 64'd1 << (2 * FRAC_BITS);
    localparam logic [63:0]        DOT_RND = (64'd1 << SH_R) >> 1;
    localparam logic signed [63:0] T_LIM   = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [49:0] TA_RND  = 50'sd1 <<< (FRAC_BITS - 1);
    localparam logic [61:0]        SQ_ONE  = 62'd1 << 60;
    localparam logic signed [49:0] RES_RND = 50'sd1 <<< 29;

    logic                    w_adv;
    logic [L_OUT:1]          r_vld;
    t_side                   r_side [1:L_OUT];
    logic signed [31:0]      r_prod [4];
    logic [61:0]             r_mm;
    logic [60:0]             r_sq_v   [0:SQRT_STEPS];
    logic [61:0]             r_sq_res [0:SQRT_STEPS];
    logic signed [ANG_W-1:0] r_vx [CORDIC_STEPS];
    logic signed [ANG_W-1:0] r_vy [CORDIC_STEPS];
    logic signed [ANG_W-1:0] r_vz [CORDIC_STEPS];
    logic signed [ANG_W-1:0] r_ang;
    logic signed [ANG_W-1:0] r_ang_d;
    logic signed [49:0]      r_tprod;
    logic signed [ANG_W-1:0] r_a0;
    logic signed [ANG_W-1:0] r_a1;
    logic signed [ANG_W-1:0] w_s0;
    logic signed [ANG_W-1:0] w_s1;
    logic signed [QUO_W-1:0] w_c0;
    logic signed [QUO_W-1:0] w_c1;
    logic signed [48:0]      r_x0h [4];
    logic signed [48:0]      r_x0l [4];
    logic signed [48:0]      r_x1h [4];
    logic signed [48:0]      r_x1l [4];
    logic signed [49:0]      r_hs [4];
    logic signed [49:0]      r_ls [4];
    logic signed [51:0]      r_tot [4];
    logic signed [15:0]      r_out [4];
    logic                    r_out_degen;

    logic signed [15:0] w_pin [4];
    logic signed [15:0] w_qin [4];
    logic signed [63:0] w_t_ext;
    logic [15:0]        w_t_cl;
    logic signed [33:0] w_dot;
    logic               w_neg;
    logic signed [33:0] w_dotp;
    logic [32:0]        w_abs;
    logic [63:0]        w_cl;
    logic [63:0]        w_m64;
    logic [MAG_W-1:0]   w_m;
    logic signed [49:0] w_ta;

    // The whole pipeline moves unless a finished result is held back.
    assign w_adv   = !(r_vld[L_OUT] && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_vld[L_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[L_OUT-1:1], i_valid};
        end
    end

    assign w_pin[0] = i_p_w;
    assign w_pin[1] = i_p_x;
    assign w_pin[2] = i_p_y;
    assign w_pin[3] = i_p_z;
    assign w_qin[0] = i_q_w;
    assign w_qin[1] = i_q_x;
    assign w_qin[2] = i_q_y;
    assign w_qin[3] = i_q_z;

    // Clamp the amount to [-1, 1].
    assign w_t_ext = 64'(i_amount);
    always_comb begin
        if (w_t_ext > T_LIM) begin
            w_t_cl = T_LIM[15:0];
        end else if (w_t_ext < -T_LIM) begin
            w_t_cl = 16'(-T_LIM);
        end else begin
            w_t_cl = i_amount;
        end
    end

    // Component products of the dot product.
    for (genvar i = 0; i < 4; i++) begin : g_prod
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_prod[i] <= w_pin[i] * w_qin[i];
            end
        end
    end

    // Sum, shortest-path flip, clamp and conversion of |dot| to Q30.
    assign w_dot = {{2{r_prod[0][31]}}, r_prod[0]} + {{2{r_prod[1][31]}}, r_prod[1]}
                 + {{2{r_prod[2][31]}}, r_prod[2]} + {{2{r_prod[3][31]}}, r_prod[3]};
    assign w_neg  = r_side[1].sp && w_dot[33];
    assign w_dotp = w_neg ? -w_dot : w_dot;
    assign w_abs  = w_dotp[33] ? 33'(-w_dotp) : w_dotp[32:0];
    assign w_cl   = (64'(w_abs) > DOT_LIM) ? DOT_LIM : 64'(w_abs);
    assign w_m64  = (SH > 0) ? ((w_cl + DOT_RND) >> SH_R) : (w_cl << SH_L);
    assign w_m    = w_m64[MAG_W-1:0];

    // Side line: operands and flags that travel with each item.
    for (genvar k = 1; k <= L_OUT; k++) begin : g_side
        t_side n_side;

        if (k == 1) begin : g_cap
            always_comb begin
                n_side       = '0;
                n_side.p     = {i_p_z, i_p_y, i_p_x, i_p_w};
                n_side.q     = {{i_q_z[15], i_q_z}, {i_q_y[15], i_q_y},
                                {i_q_x[15], i_q_x}, {i_q_w[15], i_q_w}};
                n_side.t     = w_t_cl;
                n_side.sp    = i_shortest_path;
            end
        end else if (k == L_M) begin : g_dot
            always_comb begin
                n_side = r_side[k-1];
                for (int c = 0; c < 4; c++) begin
                    n_side.q[c] = w_neg ? 17'(-$signed(r_side[k-1].q[c])) : r_side[k-1].q[c];
                end
                n_side.cneg  = w_dotp[33] && (w_m != '0);
                n_side.szero = (w_m == ONE30);
                n_side.m     = w_m;
            end
        end else if (k == L_S + 1) begin : g_sine
            always_comb begin
                n_side   = r_side[k-1];
                n_side.s = r_sq_res[SQRT_STEPS][MAG_W-1:0];
            end
        end else begin : g_pass
            assign n_side = r_side[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_side[k] <= n_side;
            end
        end
    end

    // Radicand 1 - c^2 in Q60.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mm        <= r_side[L_M].m * r_side[L_M].m;
            r_sq_v[0]   <= 61'(SQ_ONE - r_mm);
            r_sq_res[0] <= '0;
        end
    end

    // Integer square root, one result bit per stage.
    for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * (j - 1));
        logic [61:0] w_trial;
        logic        w_take;

        assign w_trial = r_sq_res[j-1] + BIT;
        assign w_take  = ({1'b0, r_sq_v[j-1]} >= w_trial);

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (w_take) begin
                    r_sq_v[j]   <= r_sq_v[j-1] - w_trial[60:0];
                    r_sq_res[j] <= (r_sq_res[j-1] >> 1) + BIT;
                end else begin
                    r_sq_v[j]   <= r_sq_v[j-1];
                    r_sq_res[j] <= r_sq_res[j-1] >> 1;
                end
            end
        end
    end

    // Vectoring CORDIC: angle of (|c|, sine) accumulates in z.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
        logic signed [ANG_W-1:0] w_px;
        logic signed [ANG_W-1:0] w_py;
        logic signed [ANG_W-1:0] w_pz;
        logic signed [ANG_W-1:0] w_atan;

        if (i == 0) begin : g_first
            assign w_px = $signed({3'b0, r_side[L_S].m});
            assign w_py = $signed({3'b0, r_sq_res[SQRT_STEPS][MAG_W-1:0]});
            assign w_pz = '0;
        end else begin : g_next
            assign w_px = r_vx[i-1];
            assign w_py = r_vy[i-1];
            assign w_pz = r_vz[i-1];
        end

        assign w_atan = $signed({4'b0, atan_q30(5'(i))});

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (w_py > 0) begin
                    r_vx[i] <= w_px + (w_py >>> i);
                    r_vy[i] <= w_py - (w_px >>> i);
                    r_vz[i] <= w_pz + w_atan;
                end else begin
                    r_vx[i] <= w_px - (w_py >>> i);
                    r_vy[i] <= w_py + (w_px >>> i);
                    r_vz[i] <= w_pz - w_atan;
                end
            end
        end
    end

    // Angle, amount times angle, and the two sine arguments.
    assign w_ta = (r_tprod + TA_RND) >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ang   <= r_side[L_VEC].cneg ? PI30 - r_vz[CORDIC_STEPS-1] : r_vz[CORDIC_STEPS-1];
            r_tprod <= $signed(r_side[L_ANG].t) * r_ang;
            r_ang_d <= r_ang;
            r_a0    <= r_ang_d - $signed(w_ta[ANG_W-1:0]);
            r_a1    <= $signed(w_ta[ANG_W-1:0]);
        end
    end

    qslerp_sin u_sin0 (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_angle (r_a0),
        .o_sin   (w_s0)
    );

    qslerp_sin u_sin1 (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_angle (r_a1),
        .o_sin   (w_s1)
    );

    // Weights: each sine divided by the sine of the angle, in Q30.
    qslerp_div u_div0 (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (w_s0),
        .i_den (r_side[L_SIN].s),
        .o_quo (w_c0)
    );

    qslerp_div u_div1 (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (w_s1),
        .i_den (r_side[L_SIN].s),
        .o_quo (w_c1)
    );

    // Weighted sum per component; each weight is split into 31-bit halves.
    for (genvar i = 0; i < 4; i++) begin : g_mix
        logic signed [49:0] w_lr;
        logic signed [51:0] w_sat_in;

        assign w_lr     = (r_ls[i] + RES_RND) >>> 30;
        assign w_sat_in = r_tot[i];

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_x0h[i] <= $signed(w_c0[QUO_W-1:MAG_W]) * $signed(r_side[L_DIV].p[i]);
                r_x0l[i] <= $signed({1'b0, w_c0[MAG_W-1:0]}) * $signed(r_side[L_DIV].p[i]);
                r_x1h[i] <= $signed(w_c1[QUO_W-1:MAG_W]) * $signed(r_side[L_DIV].q[i]);
                r_x1l[i] <= $signed({1'b0, w_c1[MAG_W-1:0]}) * $signed(r_side[L_DIV].q[i]);
                r_hs[i]  <= 50'(r_x0h[i]) + 50'(r_x1h[i]);
                r_ls[i]  <= 50'(r_x0l[i]) + 50'(r_x1l[i]);
                r_tot[i] <= $signed({r_hs[i][49], r_hs[i], 1'b0}) + 52'(w_lr);
            end
        end

        // Degenerate items return p; others saturate to 16 bits.
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (r_side[L_X3].szero) begin
                    r_out[i] <= $signed(r_side[L_X3].p[i]);
                end else if (w_sat_in > 52'sd32767) begin
                    r_out[i] <= 16'sd32767;
                end else if (w_sat_in < -52'sd32768) begin
                    r_out[i] <= -16'sd32768;
                end else begin
                    r_out[i] <= w_sat_in[15:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_degen <= r_side[L_X3].szero && r_side[L_X3].cneg;
        end
    end

    assign o_r_w        = r_out[0];
    assign o_r_x        = r_out[1];
    assign o_r_y        = r_out[2];
    assign o_r_z        = r_out[3];
    assign o_degenerate = r_out_degen;

    // The input side only stalls while a finished result is held.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    // A held pipeline keeps every valid bit in place.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !w_adv |=> $stable(r_vld))
        else $error("valid bits moved during a stall");

    // An input transfer always lands in the first stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[1])
        else $error("accepted item lost at entry");

    // The square root is zero exactly for items flagged as degenerate early.
    a_sqrt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[L_S] |-> ((r_sq_res[SQRT_STEPS][MAG_W-1:0] == '0) == r_side[L_S].szero))
        else $error("square root disagrees with the early zero-sine flag");

endmodule

`default_nettype wire

// File: hdl/qslerp_sin.sv
`default_nettype none

module qslerp_sin import qslerp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [ANG_W-1:0] i_angle,
    output logic signed [ANG_W-1:0] o_sin
);

    localparam logic signed [ANG_W-1:0] TWO_PI30 = PI30 <<< 1;

    logic signed [ANG_W-1:0] r_wrap;
    logic signed [ANG_W-1:0] r_fold;
    logic signed [ANG_W-1:0] r_x [CORDIC_STEPS];
    logic signed [ANG_W-1:0] r_y [CORDIC_STEPS];
    logic signed [ANG_W-1:0] r_z [CORDIC_STEPS];

    // Wrap the argument into [-pi, pi].
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_angle > PI30) begin
                r_wrap <= i_angle - TWO_PI30;
            end else if (i_angle < -PI30) begin
                r_wrap <= i_angle + TWO_PI30;
            end else begin
                r_wrap <= i_angle;
            end
        end
    end

    // Fold into [-pi/2, pi/2], where the sine is unchanged.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_wrap > HALF_PI30) begin
                r_fold <= PI30 - r_wrap;
            end else if (r_wrap < -HALF_PI30) begin
                r_fold <= -PI30 - r_wrap;
            end else begin
                r_fold <= r_wrap;
            end
        end
    end

    // One rotation step per stage; the residual angle picks the direction.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [ANG_W-1:0] w_px;
        logic signed [ANG_W-1:0] w_py;
        logic signed [ANG_W-1:0] w_pz;
        logic signed [ANG_W-1:0] w_atan;

        if (i == 0) begin : g_first
            assign w_px = GAIN30;
            assign w_py = '0;
            assign w_pz = r_fold;
        end else begin : g_next
            assign w_px = r_x[i-1];
            assign w_py = r_y[i-1];
            assign w_pz = r_z[i-1];
        end

        assign w_atan = $signed({4'b0, atan_q30(5'(i))});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_pz >= 0) begin
                    r_x[i] <= w_px - (w_py >>> i);
                    r_y[i] <= w_py + (w_px >>> i);
                    r_z[i] <= w_pz - w_atan;
                end else begin
                    r_x[i] <= w_px + (w_py >>> i);
                    r_y[i] <= w_py - (w_px >>> i);
                    r_z[i] <= w_pz + w_atan;
                end
            end
        end
    end

    assign o_sin = r_y[CORDIC_STEPS-1];

endmodule

`default_nettype wire

// File: hdl/qslerp_div.sv
`default_nettype none

module qslerp_div import qslerp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [ANG_W-1:0] i_num,
    input  logic [MAG_W-1:0]        i_den,
    output logic signed [QUO_W-1:0] o_quo
);

    localparam int FRAC = DIV_STEPS - MAG_W;

    logic                    r_neg [0:DIV_STEPS];
    logic [DIV_STEPS-1:0]    r_num [0:DIV_STEPS];
    logic [MAG_W-1:0]        r_den [0:DIV_STEPS];
    logic [MAG_W-1:0]        r_rem [0:DIV_STEPS];
    logic [DIV_STEPS-1:0]    r_quo [0:DIV_STEPS];
    logic signed [QUO_W-1:0] r_out;
    logic [ANG_W-1:0]        w_mag;

    // Split the numerator into sign and magnitude, scaled by 2^30.
    assign w_mag = i_num[ANG_W-1] ? ANG_W'(-i_num) : i_num;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= i_num[ANG_W-1];
            r_num[0] <= {w_mag[MAG_W-1:0], FRAC'(0)};
            r_den[0] <= i_den;
            r_rem[0] <= '0;
            r_quo[0] <= '0;
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
        logic [MAG_W:0] w_sh;
        logic [MAG_W:0] w_diff;
        logic           w_ge;

        assign w_sh   = {r_rem[j-1], r_num[j-1][DIV_STEPS-1]};
        assign w_diff = w_sh - {1'b0, r_den[j-1]};
        assign w_ge   = (w_sh >= {1'b0, r_den[j-1]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[j] <= r_neg[j-1];
                r_num[j] <= {r_num[j-1][DIV_STEPS-2:0], 1'b0};
                r_den[j] <= r_den[j-1];
                r_rem[j] <= w_ge ? w_diff[MAG_W-1:0] : w_sh[MAG_W-1:0];
                r_quo[j] <= {r_quo[j-1][DIV_STEPS-2:0], w_ge};
            end
        end
    end

    // Restore the sign; the quotient truncates toward zero.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[DIV_STEPS]) begin
                r_out <= -$signed({1'b0, r_quo[DIV_STEPS]});
            end else begin
                r_out <= $signed({1'b0, r_quo[DIV_STEPS]});
            end
        end
    end

    assign o_quo = r_out;

endmodule

`default_nettype wire
